FILE: hw/rtl/button_debounce_long_press_top_assert.svh
// ----------------------------------------------------------------------------
// Button debounce assertion macros
// Shared property macros for the checker of the button debouncer.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_TOP_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_TOP_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge, quiet in reset
`define BDLP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("button debounce check failed");

// next-cycle implication, sampled on the rising clock edge, quiet in reset
`define BDLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("button debounce check failed");

`endif

FILE: hw/rtl/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// Button debounce package
// Codes and types shared by the debouncer and its checker.
// ----------------------------------------------------------------------------
package bdlp_pkg;

   // transaction kinds on the request channel
   typedef enum logic {
      OP_EDGE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   // result event codes
   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_PRESS   = 3'd1,
      EV_RELEASE = 3'd2,
      EV_LONG    = 3'd3,
      EV_ULTRA   = 3'd4
   } event_type;

   // held-button mode
   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_LONG   = 2'd1,
      MODE_ULTRA  = 2'd2
   } press_mode_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_DEBOUNCE   = 2'd0,
      CSR_LONG_PRESS = 2'd1,
      CSR_ULTRA_LONG = 2'd2
   } csr_index_type;

   localparam int unsigned THR_BITS = 31;

   localparam logic [THR_BITS-1:0] DEBOUNCE_RESET   = 31'd50000;
   localparam logic [THR_BITS-1:0] LONG_PRESS_RESET = 31'd2000000;
   localparam logic [THR_BITS-1:0] ULTRA_LONG_RESET = 31'd10000000;

endpackage

FILE: hw/rtl/button_debounce_long_press_top.sv
// ----------------------------------------------------------------------------
// Button debouncer with long-press detection
// Debounces edge notices against ticks and reports press, release, long press
// and ultra-long press events.
// ----------------------------------------------------------------------------
// One transaction is accepted every clock cycle while the result side does not
// stall, and every transaction gives exactly one result. A request is caught in
// an input register and the whole state update (two wrapped time differences and
// their threshold compares) runs from there into the result register, which
// offers the result. A stalled result holds the input register, and the request
// side waits only while both registers are full. Configuration writes are always
// taken and should be made while no transaction is in flight.
module button_debounce_long_press_top #(
   parameter int unsigned TIME_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_op,
   input  logic signed [31:0]             req_now,
   input  logic                           req_pin_level,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [2:0]                     rsp_event_res,
   // configuration channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [bdlp_pkg::THR_BITS-1:0]  csr_wdata
);

   localparam int unsigned CMP_BITS = 64;

   // true when (a - b), as a signed wrapped difference, reaches thr
   function automatic logic aged(input logic [TIME_BITS-1:0] a,
                                 input logic [TIME_BITS-1:0] b,
                                 input logic [bdlp_pkg::THR_BITS-1:0] thr);
      logic [TIME_BITS-1:0] diff;
      begin
         diff = a - b;
         aged = !diff[TIME_BITS-1] && (CMP_BITS'(diff) >= CMP_BITS'(thr));
      end
   endfunction

   // configuration registers
   logic [bdlp_pkg::THR_BITS-1:0] debounce_ff;
   logic [bdlp_pkg::THR_BITS-1:0] long_press_ff;
   logic [bdlp_pkg::THR_BITS-1:0] ultra_long_ff;

   // input register
   logic                     in_valid_ff;
   bdlp_pkg::op_type         in_op_ff;
   logic [TIME_BITS-1:0]     in_now_ff;
   logic                     in_pin_ff;

   // debouncer state
   logic                     change_pending_ff, change_pending_in;
   logic [TIME_BITS-1:0]     change_time_ff, change_time_in;
   logic                     pressed_ff, pressed_in;
   logic [TIME_BITS-1:0]     stable_since_ff, stable_since_in;
   bdlp_pkg::press_mode_type press_mode_ff, press_mode_in;

   // result register
   logic                     out_valid_ff;
   bdlp_pkg::event_type      out_event_ff, out_event_in;

   logic                     advance;
   logic                     req_take;
   logic signed [63:0]       now_ext;
   logic                     level;

   // handshakes
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid     = out_valid_ff;
   assign rsp_event_res = out_event_ff;

   // sign-extend the request time, then keep the configured time width
   assign now_ext = 64'(req_now);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= bdlp_pkg::DEBOUNCE_RESET;
         long_press_ff <= bdlp_pkg::LONG_PRESS_RESET;
         ultra_long_ff <= bdlp_pkg::ULTRA_LONG_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bdlp_pkg::CSR_DEBOUNCE:   debounce_ff   <= csr_wdata;
            bdlp_pkg::CSR_LONG_PRESS: long_press_ff <= csr_wdata;
            bdlp_pkg::CSR_ULTRA_LONG: ultra_long_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff  <= bdlp_pkg::op_type'(req_op);
         in_now_ff <= now_ext[TIME_BITS-1:0];
         in_pin_ff <= req_pin_level;
      end
   end

   // state update and event for the transaction in the input register
   always_comb begin
      change_pending_in = change_pending_ff;
      change_time_in    = change_time_ff;
      pressed_in        = pressed_ff;
      stable_since_in   = stable_since_ff;
      press_mode_in     = press_mode_ff;
      out_event_in      = bdlp_pkg::EV_NONE;
      level             = pressed_ff;

      case (in_op_ff)
         bdlp_pkg::OP_EDGE: begin
            change_pending_in = 1'b1;
            change_time_in    = in_now_ff;
         end
         bdlp_pkg::OP_TICK: begin
            // sample the pin once the change has aged
            if (change_pending_ff && aged(in_now_ff, change_time_ff, debounce_ff)) begin
               change_pending_in = 1'b0;
               level             = in_pin_ff;
            end
            if (level != pressed_ff) begin
               pressed_in      = level;
               stable_since_in = in_now_ff;
               if (press_mode_ff == bdlp_pkg::MODE_NORMAL) begin
                  out_event_in = level ? bdlp_pkg::EV_PRESS : bdlp_pkg::EV_RELEASE;
               end else begin
                  press_mode_in = bdlp_pkg::MODE_NORMAL;
               end
            end else if (pressed_ff) begin
               // held button: long press, then ultra-long press
               if (press_mode_ff == bdlp_pkg::MODE_NORMAL &&
                   aged(in_now_ff, stable_since_ff, long_press_ff)) begin
                  press_mode_in = bdlp_pkg::MODE_LONG;
                  out_event_in  = bdlp_pkg::EV_LONG;
               end else if (press_mode_ff == bdlp_pkg::MODE_LONG &&
                            aged(in_now_ff, stable_since_ff, ultra_long_ff)) begin
                  press_mode_in = bdlp_pkg::MODE_ULTRA;
                  out_event_in  = bdlp_pkg::EV_ULTRA;
               end
            end
         end
         default: ;
      endcase
   end

   // debouncer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         change_pending_ff <= 1'b0;
         change_time_ff    <= '0;
         pressed_ff        <= 1'b0;
         stable_since_ff   <= '0;
         press_mode_ff     <= bdlp_pkg::MODE_NORMAL;
      end else if (in_valid_ff && advance) begin
         change_pending_ff <= change_pending_in;
         change_time_ff    <= change_time_in;
         pressed_ff        <= pressed_in;
         stable_since_ff   <= stable_since_in;
         press_mode_ff     <= press_mode_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff && advance) begin
         out_event_ff <= out_event_in;
      end
   end

endmodule

FILE: hw/rtl/bdlp_checker.sv
// ----------------------------------------------------------------------------
// Button debounce checker
// Port-level checks on the debouncer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "button_debounce_long_press_top_assert.svh"

module bdlp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_event_res
);

   // no result is shown straight after reset
   `BDLP_ASSERT_IMPL(a_rsp_clear_after_reset, clock, reset, $past(reset), !rsp_valid)

   // event codes stay within the defined set
   `BDLP_ASSERT_IMPL(a_event_in_range, clock, reset, rsp_valid, rsp_event_res == bdlp_pkg::EV_NONE || rsp_event_res == bdlp_pkg::EV_PRESS || rsp_event_res == bdlp_pkg::EV_RELEASE || rsp_event_res == bdlp_pkg::EV_LONG || rsp_event_res == bdlp_pkg::EV_ULTRA)

   // requests are only held back while the result side is stalled
   `BDLP_ASSERT_IMPL(a_ready_when_drained, clock, reset, !rsp_valid || rsp_ready, req_ready)

   // a stalled result keeps its transaction
   `BDLP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_event_res))

endmodule

bind button_debounce_long_press_top bdlp_checker u_bdlp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_event_res (rsp_event_res)
);

FILE: test/button_debounce_long_press_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button debouncer testbench
// Drives edge and tick transactions with random pacing on both channels and
// checks every event against a cycle-free model of the debounce and the
// long-press timing, across reset, zero, maximum and random thresholds.
// ----------------------------------------------------------------------------

// expected-event tracking: debounce state, thresholds and pending events
class debounce_scoreboard;
   logic [30:0]              debounce_us;
   logic [30:0]              long_press_us;
   logic [30:0]              ultra_long_us;
   logic                     change_pending;
   logic [31:0]              change_time;
   logic                     pressed;
   logic [31:0]              stable_since;
   bdlp_pkg::press_mode_type mode;
   bdlp_pkg::event_type      expected_events[$];
   int                       mismatches;

   function new();
      debounce_us    = bdlp_pkg::DEBOUNCE_RESET;
      long_press_us  = bdlp_pkg::LONG_PRESS_RESET;
      ultra_long_us  = bdlp_pkg::ULTRA_LONG_RESET;
      change_pending = 1'b0;
      change_time    = '0;
      pressed        = 1'b0;
      stable_since   = '0;
      mode           = bdlp_pkg::MODE_NORMAL;
      mismatches     = 0;
   endfunction

   // wrapped difference, negative ages never reach a threshold
   function bit has_aged(logic [31:0] later, logic [31:0] earlier, logic [30:0] limit);
      logic [31:0] age;
      age = later - earlier;
      return !age[31] && (age[30:0] >= limit);
   endfunction

   function void write_register(logic [1:0] index, logic [30:0] value);
      case (index)
         bdlp_pkg::CSR_DEBOUNCE:   debounce_us   = value;
         bdlp_pkg::CSR_LONG_PRESS: long_press_us = value;
         bdlp_pkg::CSR_ULTRA_LONG: ultra_long_us = value;
         default: ;
      endcase
   endfunction

   function int outstanding();
      return expected_events.size();
   endfunction

   function void note_request(bdlp_pkg::op_type op, logic [31:0] now, logic pin_level);
      bdlp_pkg::event_type ev;
      logic                level;
      ev    = bdlp_pkg::EV_NONE;
      level = pressed;
      if (op == bdlp_pkg::OP_EDGE) begin
         // a newer edge restarts the debounce wait
         change_pending = 1'b1;
         change_time    = now;
      end else begin
         if (change_pending && has_aged(now, change_time, debounce_us)) begin
            change_pending = 1'b0;
            level          = pin_level;
         end
         if (level != pressed) begin
            // stable change, swallowed after a long mode
            pressed      = level;
            stable_since = now;
            if (mode == bdlp_pkg::MODE_NORMAL)
               ev = level ? bdlp_pkg::EV_PRESS : bdlp_pkg::EV_RELEASE;
            else
               mode = bdlp_pkg::MODE_NORMAL;
         end else if (pressed) begin
            if (mode == bdlp_pkg::MODE_NORMAL &&
                has_aged(now, stable_since, long_press_us)) begin
               mode = bdlp_pkg::MODE_LONG;
               ev   = bdlp_pkg::EV_LONG;
            end else if (mode == bdlp_pkg::MODE_LONG &&
                         has_aged(now, stable_since, ultra_long_us)) begin
               mode = bdlp_pkg::MODE_ULTRA;
               ev   = bdlp_pkg::EV_ULTRA;
            end
         end
      end
      expected_events.push_back(ev);
   endfunction

   function void check_event(logic [2:0] actual);
      bdlp_pkg::event_type wanted;
      if (expected_events.size() == 0) begin
         $error("event_res: no transaction waiting, expected none, actual %0d", actual);
         mismatches++;
      end else begin
         wanted = expected_events.pop_front();
         if (actual !== wanted) begin
            $error("event_res: expected %0d, actual %0d", wanted, actual);
            mismatches++;
         end
      end
   endfunction
endclass

module button_debounce_long_press_top_test;

   localparam logic [1:0] CSR_SPARE     = 2'd3;
   localparam int         HOLD_CYCLES   = 40;
   localparam int         STALL_LIMIT   = 2000;
   localparam int         DRAIN_CYCLES  = 8;
   localparam int         RANDOM_PHASES = 5;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic                          req_op;
   logic signed [31:0]            req_now;
   logic                          req_pin_level;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [2:0]                    rsp_event_res;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [1:0]                    csr_index;
   logic [bdlp_pkg::THR_BITS-1:0] csr_wdata;

   debounce_scoreboard board = new();

   // stimulus state
   logic [30:0] cur_debounce;
   logic [30:0] cur_ultra;
   logic [31:0] clock_us;
   logic        button_down;
   bit          quiet;
   bit          hold_results;
   int          sender_idle_pct;
   int          receiver_stall_pct;

   button_debounce_long_press_top i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_now       (req_now),
      .req_pin_level (req_pin_level),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_event_res (rsp_event_res),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result checking on the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_event(rsp_event_res);
   end

   // result side back-pressure: random stalls and one long hold-off
   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_results) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_results = 1'b0;
            rsp_ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 99) < receiver_stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transaction
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("button_debounce_long_press_top: mismatch");
      $finish;
   end

   // offer one transaction from a falling edge, return on the falling edge after it
   task automatic send_request(input bdlp_pkg::op_type op, input logic [31:0] now,
                               input logic pin);
      req_valid     <= 1'b1;
      req_op        <= op;
      req_now       <= now;
      req_pin_level <= pin;
      do @(posedge clock); while (!req_ready);
      board.note_request(op, now, pin);
      @(negedge clock);
   endtask

   task automatic pace_sender();
      if (!quiet && $urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(negedge clock);
   endtask

   // leaves csr_valid high so that back-to-back writes need no gap
   task automatic write_register(input logic [1:0] index, input logic [30:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      board.write_register(index, value);
      @(negedge clock);
   endtask

   task automatic set_thresholds(input logic [30:0] debounce_us, input logic [30:0] long_us,
                                 input logic [30:0] ultra_us);
      wait_for_drain();
      // the unused index must leave every threshold alone
      write_register(CSR_SPARE, 31'($urandom));
      write_register(bdlp_pkg::CSR_DEBOUNCE, debounce_us);
      write_register(bdlp_pkg::CSR_LONG_PRESS, long_us);
      write_register(bdlp_pkg::CSR_ULTRA_LONG, ultra_us);
      csr_valid    <= 1'b0;
      cur_debounce = debounce_us;
      cur_ultra    = ultra_us;
   endtask

   // hand-picked sequence under the reset thresholds
   task automatic run_directed();
      logic [31:0] t;
      // tick without a pending change ignores the pin
      send_request(bdlp_pkg::OP_TICK, 32'd0, 1'b1);
      // a further edge restarts the wait, then press exactly at the threshold
      send_request(bdlp_pkg::OP_EDGE, 32'd1000, 1'b0);
      send_request(bdlp_pkg::OP_TICK, 32'd50999, 1'b1);
      send_request(bdlp_pkg::OP_EDGE, 32'd51000, 1'b0);
      send_request(bdlp_pkg::OP_TICK, 32'd100999, 1'b1);
      send_request(bdlp_pkg::OP_TICK, 32'd101000, 1'b1);
      // long then ultra-long while held
      send_request(bdlp_pkg::OP_TICK, 32'd2101000, 1'b1);
      send_request(bdlp_pkg::OP_TICK, 32'd10100999, 1'b1);
      send_request(bdlp_pkg::OP_TICK, 32'd10101000, 1'b1);
      // release after ultra-long is swallowed
      send_request(bdlp_pkg::OP_EDGE, 32'd10200000, 1'b1);
      send_request(bdlp_pkg::OP_TICK, 32'd10250000, 1'b0);
      // plain press and release, with a negative age in between
      send_request(bdlp_pkg::OP_EDGE, 32'd10300000, 1'b0);
      send_request(bdlp_pkg::OP_TICK, 32'd10350000, 1'b1);
      send_request(bdlp_pkg::OP_EDGE, 32'd10400000, 1'b0);
      send_request(bdlp_pkg::OP_TICK, 32'd10399995, 1'b0);
      send_request(bdlp_pkg::OP_TICK, 32'd10450000, 1'b0);
      // press across the signed wrap of the time counter
      t = 32'h7FFF_FFFF;
      send_request(bdlp_pkg::OP_EDGE, t, 1'b0);
      t = t + 32'd50000;
      send_request(bdlp_pkg::OP_TICK, t, 1'b1);
      // half a wrap away counts as negative, no long press
      send_request(bdlp_pkg::OP_TICK, t + 32'h8000_0000, 1'b1);
      t = t + 32'd2000000;
      send_request(bdlp_pkg::OP_TICK, t, 1'b1);
      // release after long press is swallowed
      send_request(bdlp_pkg::OP_EDGE, t, 1'b1);
      send_request(bdlp_pkg::OP_TICK, t + 32'd50000, 1'b0);
      send_request(bdlp_pkg::OP_TICK, 32'hFFFF_FFFF, 1'b1);
      send_request(bdlp_pkg::OP_TICK, 32'h8000_0000, 1'b0);
   endtask

   // bouncing button on a moving clock, with some noise and backward steps
   task automatic run_random_phase(input int count, input bit with_pause);
      int unsigned      span;
      logic [31:0]      now;
      bdlp_pkg::op_type op;
      logic             pin;
      int               roll;
      int               k;
      for (k = 0; k < count; k++) begin
         if (with_pause && k == count / 2)
            wait_for_drain();
         pace_sender();
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            op  = bdlp_pkg::op_type'($urandom_range(0, 1));
            now = $urandom;
            pin = 1'($urandom_range(0, 1));
         end else begin
            roll = $urandom_range(0, 9);
            if (roll == 9) begin
               clock_us = clock_us - $urandom_range(1, cur_debounce + 1);
            end else begin
               if (roll < 6)
                  span = cur_debounce + (cur_debounce >> 1) + 2;
               else
                  span = (cur_ultra >> 2) + 2;
               clock_us = clock_us + $urandom_range(0, span);
            end
            now = clock_us;
            if ($urandom_range(0, 9) < 3) begin
               op = bdlp_pkg::OP_EDGE;
               if ($urandom_range(0, 1) == 1)
                  button_down = ~button_down;
            end else begin
               op = bdlp_pkg::OP_TICK;
            end
            pin = ($urandom_range(0, 9) == 0) ? ~button_down : button_down;
         end
         send_request(op, now, pin);
      end
   endtask

   // main sequence
   initial begin
      int phase;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_op             = bdlp_pkg::OP_EDGE;
      req_now            = '0;
      req_pin_level      = 1'b0;
      csr_valid          = 1'b0;
      csr_index          = bdlp_pkg::CSR_DEBOUNCE;
      csr_wdata          = '0;
      quiet              = 1'b0;
      hold_results       = 1'b0;
      sender_idle_pct    = 15;
      receiver_stall_pct = 15;
      clock_us           = '0;
      button_down        = 1'b0;
      cur_debounce       = bdlp_pkg::DEBOUNCE_RESET;
      cur_ultra          = bdlp_pkg::ULTRA_LONG_RESET;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      run_directed();

      // zero thresholds: every aged tick samples at once
      set_thresholds('0, '0, '0);
      run_random_phase(60, 1'b0);

      // maximum thresholds, reached only at the largest positive age
      set_thresholds('1, '1, '1);
      send_request(bdlp_pkg::OP_EDGE, clock_us, 1'b0);
      send_request(bdlp_pkg::OP_TICK, clock_us + 32'h7FFF_FFFE, ~board.pressed);
      send_request(bdlp_pkg::OP_TICK, clock_us + 32'h7FFF_FFFF, ~board.pressed);
      run_random_phase(40, 1'b0);

      // short random thresholds so that long and ultra-long events occur often
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_thresholds(31'($urandom_range(0, 300)), 31'($urandom_range(0, 3000)),
                        31'($urandom_range(0, 8000)));
         sender_idle_pct    = (phase == 2) ? 0 : $urandom_range(5, 30);
         receiver_stall_pct = (phase == 2) ? 0 : $urandom_range(5, 30);
         if (phase == 0)
            hold_results = 1'b1;
         if (phase == RANDOM_PHASES - 1)
            quiet = 1'b1;
         run_random_phase(90, phase == 1);
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (board.mismatches == 0 && board.outstanding() == 0)
         $display("button_debounce_long_press_top: match");
      else
         $display("button_debounce_long_press_top: mismatch");
      $finish;
   end

endmodule
